FILE: design/bmo5_pkg.sv
`default_nettype none
package bmo5_pkg;

  // Groups held between the collector and the median pipeline.
  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

FILE: design/bmo5_front.sv
`default_nettype none
module bmo5_front #(
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0]          sample_i,
  input  wire logic                            end_of_block_i,
  input  wire bmo5_pkg::q_status_t             q_status_i,
  output logic                                 push_o,
  output logic [WINDOW*SAMPLE_BITS-1:0]        group_o
);

  localparam int unsigned CntW = $clog2(WINDOW);

  logic [CntW-1:0]        fill_q, fill_d;
  logic [SAMPLE_BITS-1:0] hist_q [WINDOW-1];
  logic                   accept;
  logic                   last_of_group;

  assign in_ready_o    = !q_status_i.full;
  assign accept        = in_valid_i && in_ready_o;
  assign last_of_group = (fill_q == CntW'(WINDOW - 1));
  assign push_o        = accept && last_of_group;

  always_comb begin
    fill_d = fill_q;
    if (accept) begin
      if (end_of_block_i || last_of_group) begin
        fill_d = '0;
      end else begin
        fill_d = fill_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  // Sample history; order within a group does not matter for the median.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hist_q[0] <= sample_i;
      for (int i = 1; i < WINDOW - 1; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  always_comb begin
    group_o[SAMPLE_BITS-1:0] = sample_i;
    for (int i = 0; i < WINDOW - 1; i++) begin
      group_o[(i+1)*SAMPLE_BITS +: SAMPLE_BITS] = hist_q[i];
    end
  end

endmodule
`default_nettype wire

FILE: design/bmo5_queue.sv
`default_nettype none
module bmo5_queue #(
  parameter int unsigned DATA_BITS = 80
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic [DATA_BITS-1:0] wdata_i,
  input  wire logic                 pop_i,
  output logic [DATA_BITS-1:0]      rdata_o,
  output bmo5_pkg::q_status_t       status_o
);

  localparam int unsigned Depth = bmo5_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [DATA_BITS-1:0] mem_q [Depth];
  logic [PtrW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]      cnt_q;
  logic                 do_push, do_pop;

  assign status_o.full  = (cnt_q == CntW'(Depth));
  assign status_o.empty = (cnt_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign rdata_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

FILE: design/bmo5_back.sv
`default_nettype none
module bmo5_back #(
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire bmo5_pkg::q_status_t             q_status_i,
  input  wire logic [WINDOW*SAMPLE_BITS-1:0]   group_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [SAMPLE_BITS-1:0]               median_o
);

  localparam int unsigned RankW = $clog2(WINDOW);
  localparam int unsigned Mid   = WINDOW / 2;

  logic                   s1_vld_q;
  logic [SAMPLE_BITS-1:0] s1_val_q [WINDOW];
  logic [WINDOW-1:0]      s1_pre_q [WINDOW];
  logic [WINDOW-1:0]      pre_d    [WINDOW];
  logic                   out_vld_q;
  logic [SAMPLE_BITS-1:0] med_q, med_d;
  logic                   out_adv, s1_adv;

  assign out_adv     = !out_vld_q || out_ready_i;
  assign s1_adv      = s1_vld_q && out_adv;
  assign pop_o       = !q_status_i.empty && (!s1_vld_q || out_adv);
  assign out_valid_o = out_vld_q;
  assign median_o    = med_q;

  // Stage 1: all pairwise orderings; ties broken by position.
  always_comb begin
    logic [SAMPLE_BITS-1:0] vi, vj;
    for (int i = 0; i < WINDOW; i++) begin
      vi = group_i[i*SAMPLE_BITS +: SAMPLE_BITS];
      for (int j = 0; j < WINDOW; j++) begin
        vj = group_i[j*SAMPLE_BITS +: SAMPLE_BITS];
        pre_d[i][j] = (vj < vi) || ((vj == vi) && (j < i));
      end
    end
  end

  // Stage 2: the element with exactly Mid predecessors is the median.
  always_comb begin
    logic [RankW-1:0] rank;
    med_d = '0;
    for (int i = 0; i < WINDOW; i++) begin
      rank = '0;
      for (int j = 0; j < WINDOW; j++) begin
        rank = rank + RankW'(s1_pre_q[i][j]);
      end
      if (rank == RankW'(Mid)) begin
        med_d = med_d | s1_val_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        s1_vld_q <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < WINDOW; i++) begin
        s1_val_q[i] <= group_i[i*SAMPLE_BITS +: SAMPLE_BITS];
        s1_pre_q[i] <= pre_d[i];
      end
    end
    if (s1_adv) begin
      med_q <= med_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/block_median_of_five_core.sv
// Gathers samples into consecutive groups of WINDOW and returns the median of
// each full group; end_of_block drops any partial group. One sample is taken
// per cycle while the two-entry group queue has room, and the median pipeline
// drains one group per cycle while out_ready is high, so the sustained rate is
// one sample per cycle unless the output stalls. The group is written to the
// queue on the edge that takes its last sample, then passes the pairwise
// compare stage and the rank/select stage into the output register.
`default_nettype none
module block_median_of_five_core #(
  parameter int unsigned WINDOW      = 5,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                   end_of_block_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [SAMPLE_BITS-1:0]      median_o
);

  localparam int unsigned GroupBits = WINDOW * SAMPLE_BITS;

  bmo5_pkg::q_status_t  q_status;
  logic                 push, pop;
  logic [GroupBits-1:0] wgroup, rgroup;

  bmo5_front #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .end_of_block_i (end_of_block_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .group_o        (wgroup)
  );

  bmo5_queue #(
    .DATA_BITS (GroupBits)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .wdata_i  (wgroup),
    .pop_i    (pop),
    .rdata_o  (rgroup),
    .status_o (q_status)
  );

  bmo5_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_status_i  (q_status),
    .group_i     (rgroup),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .median_o    (median_o)
  );

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GroupSize   = 5;
  localparam int unsigned SampleBits  = 16;
  localparam int unsigned ItemTarget  = 1300;
  localparam int unsigned PauseAt     = 640;
  localparam int unsigned HoldAt      = 40;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned DrainCycles = 10;

  typedef logic [SampleBits-1:0] sample_t;

  typedef enum int unsigned {
    VAL_WIDE,
    VAL_NARROW,
    VAL_EXTREME
  } value_style_t;

  typedef struct packed {
    sample_t sample;
    logic    eob;
    logic    known;
    sample_t median;
  } stim_row_t;

  // known = 1: median typed in here, otherwise taken from the group model
  localparam stim_row_t DirectedRows [24] = '{
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b1, 16'h0000},
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
    '{16'h0005, 1'b0, 1'b0, 16'h0000},
    '{16'h0001, 1'b0, 1'b0, 16'h0000},
    '{16'h0004, 1'b0, 1'b0, 16'h0000},
    '{16'h0002, 1'b0, 1'b0, 16'h0000},
    '{16'h0003, 1'b1, 1'b0, 16'h0000},
    '{16'h0007, 1'b0, 1'b0, 16'h0000},
    '{16'h0008, 1'b0, 1'b0, 16'h0000},
    '{16'h0009, 1'b1, 1'b0, 16'h0000},
    '{16'h1234, 1'b1, 1'b0, 16'h0000},
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000},
    '{16'h0000, 1'b0, 1'b0, 16'h0000},
    '{16'h8000, 1'b0, 1'b0, 16'h0000},
    '{16'h7FFF, 1'b0, 1'b0, 16'h0000},
    '{16'h0001, 1'b0, 1'b0, 16'h0000}
  };

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_ready_o;
  sample_t sample_i;
  logic    end_of_block_i;
  logic    out_valid_o;
  logic    out_ready_i;
  sample_t median_o;

  block_median_of_five_core #(
    .WINDOW     (GroupSize),
    .SAMPLE_BITS(SampleBits)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_i      (sample_i),
    .end_of_block_i(end_of_block_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .median_o      (median_o)
  );

  sample_t     group_samples [GroupSize];
  int unsigned group_fill;
  sample_t     median_q [$];
  int unsigned medians_seen;
  int unsigned errors;
  bit          tx_calm;
  sample_t     median_want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t group_median();
    sample_t v [GroupSize];
    sample_t t;
    for (int i = 0; i < GroupSize; i++) v[i] = group_samples[i];
    for (int i = 0; i < GroupSize - 1; i++) begin
      for (int j = 0; j < GroupSize - 1 - i; j++) begin
        if (v[j] > v[j+1]) begin
          t = v[j];
          v[j] = v[j+1];
          v[j+1] = t;
        end
      end
    end
    return v[GroupSize/2];
  endfunction

  function automatic void gather_sample(input sample_t s, input logic eob, input logic known,
                                        input sample_t known_median);
    group_samples[group_fill] = s;
    group_fill++;
    if (group_fill == GroupSize) begin
      median_q.push_back(known ? known_median : group_median());
      group_fill = 0;
    end
    if (eob) group_fill = 0;
  endfunction

  function automatic sample_t pick_sample(input value_style_t style);
    case (style)
      VAL_NARROW: return sample_t'($urandom_range(0, 3));
      VAL_EXTREME: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hFFFF;
          2: return 16'h7FFF;
          default: return 16'h8000;
        endcase
      end
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic push_sample(input sample_t s, input logic eob, input logic known,
                             input sample_t known_median);
    int unsigned gap;
    gap = idle_gap(tx_calm);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_i       <= s;
    end_of_block_i <= eob;
    do @(posedge clk_i); while (!in_ready_o);
    gather_sample(s, eob, known, known_median);
  endtask

  task automatic wait_for_medians();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (median_q.size() == 0) begin
        $error("median: unexpected transaction, actual %h", median_o);
        errors++;
      end else begin
        median_want = median_q.pop_front();
        if (median_o !== median_want) begin
          $error("median: expected %h, actual %h", median_want, median_o);
          errors++;
        end
      end
      medians_seen++;
    end
  end

  // receiver; one long hold-off fills the block and backs up the input
  initial begin : sink
    int unsigned stall;
    bit          held;
    bit          calm;
    held        = 1'b0;
    calm        = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      if ($urandom_range(0, 15) == 0) calm = ~calm;
      if (!held && medians_seen >= HoldAt) begin
        held  = 1'b1;
        stall = HoldCycles;
      end else begin
        stall = idle_gap(calm);
      end
      if (stall != 0) begin
        @(negedge clk_i);
        out_ready_i <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("** block_median_of_five_core: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int unsigned  sent;
    int unsigned  len;
    int unsigned  r;
    bit           paused;
    value_style_t style;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    sample_i       = '0;
    end_of_block_i = 1'b0;
    group_fill     = 0;
    medians_seen   = 0;
    errors         = 0;
    tx_calm        = 1'b0;
    paused         = 1'b0;
    for (int i = 0; i < GroupSize; i++) group_samples[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) begin
      push_sample(DirectedRows[i].sample, DirectedRows[i].eob, DirectedRows[i].known,
                  DirectedRows[i].median);
    end
    sent = $size(DirectedRows);
    wait_for_medians();

    // blocks: mostly whole groups, some ragged, some single marked samples
    while (sent < ItemTarget) begin
      if (!paused && sent >= PauseAt) begin
        paused = 1'b1;
        wait_for_medians();
      end
      r = $urandom_range(0, 9);
      if (r < 7) len = GroupSize * $urandom_range(1, 4);
      else if (r < 9) len = $urandom_range(1, 14);
      else len = 1;
      r = $urandom_range(0, 9);
      if (r < 6) style = VAL_WIDE;
      else if (r < 8) style = VAL_NARROW;
      else style = VAL_EXTREME;
      tx_calm = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
        push_sample(pick_sample(style), (i == len - 1), 1'b0, '0);
      end
      sent += len;
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (median_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("** block_median_of_five_core: PASSED **");
    end else begin
      $display("** block_median_of_five_core: FAILED **");
    end
    $finish;
  end

endmodule
`default_nettype wire
